>>> rtl/core/vaq_pkg.sv
// Shared widths, constants and register map of the velocity-adaptive readout quantizer.
`default_nettype none

package vaq_pkg;

	// stream and register port widths
	localparam int S_TDATA_W = 56;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 24;
	localparam int M_TUSER_W = 3;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	localparam int VAL_W  = 24;
	localparam int TIME_W = 32;

	// register indexes
	localparam logic [2:0] REG_SETTLE_MS   = 3'd0;
	localparam logic [2:0] REG_FAST_SPEED  = 3'd1;
	localparam logic [2:0] REG_SLOW_SPEED  = 3'd2;
	localparam logic [2:0] REG_CHANGE_DB   = 3'd3;
	localparam logic [2:0] REG_REDRAW_DB   = 3'd4;

	// register reset values
	localparam logic [15:0] SETTLE_MS_RST  = 16'd150;
	localparam logic [19:0] FAST_SPEED_RST = 20'd5000;
	localparam logic [19:0] SLOW_SPEED_RST = 20'd2000;
	localparam logic [15:0] CHANGE_DB_RST  = 16'd10;
	localparam logic [15:0] REDRAW_DB_RST  = 16'd150;

	// value constants in thousandths of the display unit
	localparam logic [VAL_W-1:0] SENTINEL    = 24'(-32'sd999900);
	localparam logic [VAL_W-1:0] METER_LIMIT = 24'd999950;
	localparam logic [VAL_W-1:0] VAL_MAX     = 24'h7FFFFF;
	localparam logic [VAL_W-1:0] VAL_MIN     = 24'h800000;
	localparam logic [1:0]       UNIT_NONE   = 2'd3;

	// milli-inch = (|pos| * 50 + 63) / 127, the divide done by reciprocal
	localparam logic [28:0] INCH_MUL   = 29'd50;
	localparam logic [28:0] INCH_BIAS  = 29'd63;
	localparam logic [29:0] INCH_RECIP = 30'd541098243;
	localparam int          INCH_SHIFT = 36;

	// rounding steps: reciprocals scaled by 2^RND_SHIFT, exact for inputs below 2^24
	localparam logic [27:0] RECIP_1000 = 28'd34359739;
	localparam logic [27:0] RECIP_500  = 28'd68719477;
	localparam logic [27:0] RECIP_200  = 28'd171798692;
	localparam int          RND_SHIFT  = 35;

	localparam logic [9:0] STEP_1000_VAL = 10'd1000;
	localparam logic [9:0] STEP_500_VAL  = 10'd500;
	localparam logic [9:0] STEP_200_VAL  = 10'd200;

	// speed is |delta| * SPEED_SCALE / dt
	localparam logic [33:0] SPEED_SCALE = 34'd1000;
	localparam int          DIV_STEPS   = 32;

endpackage

`default_nettype wire

>>> rtl/core/velocity_adaptive_readout_quantizer.sv
// Velocity-adaptive readout quantizer. Each input transfer carries a position in 0.01 mm,
// a millisecond timestamp and an inch flag; the block converts it to milli-cm or milli-inch,
// tracks movement against a deadband, holds a speed in milli-units per second and returns one
// result transfer with the display value (exact once settled, else rounded to 1000, 500 or
// 200 milli-units by speed) and the just-settled, redraw and meter-range flags. An item that
// does not update the speed skips the bit-serial speed divider; one that does goes through
// it, one quotient bit per cycle (a speed that saturates skips it). A stalled result holds
// the last step until the output register frees. Registers are to be written over the APB
// port only while the block is idle; the block itself does not enforce this.
`default_nettype none

module velocity_adaptive_readout_quantizer (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_tvalid,
	output logic                           s_tready,
	input  wire  [vaq_pkg::S_TDATA_W-1:0]  s_tdata,  // [23:0] position, [55:24] time_ms
	input  wire  [vaq_pkg::S_TUSER_W-1:0]  s_tuser,  // [0] inch_mode
	output logic                           m_tvalid,
	input  wire                            m_tready,
	output logic [vaq_pkg::M_TDATA_W-1:0]  m_tdata,  // [23:0] shown_value
	output logic [vaq_pkg::M_TUSER_W-1:0]  m_tuser,  // [0] just_settled, [1] redraw, [2] meter_range
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire  [vaq_pkg::ADDR_W-1:0]     paddr,
	input  wire  [vaq_pkg::DATA_W-1:0]     pwdata,
	output logic [vaq_pkg::DATA_W-1:0]     prdata,
	output logic                           pready
);
	import vaq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_DELTA,
		ST_DIV,
		ST_ROUND,
		ST_SCALE,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		STEP_200,
		STEP_500,
		STEP_1000
	} step_t;

	state_t state_q;

	// configuration
	logic [15:0] settle_ms_q;
	logic [19:0] fast_speed_q;
	logic [19:0] slow_speed_q;
	logic [15:0] change_db_q;
	logic [15:0] redraw_db_q;

	// item in flight
	logic [VAL_W-1:0]  pos_q;
	logic [TIME_W-1:0] time_q;
	logic              inch_q;
	logic [VAL_W-1:0]  v_q;
	logic              settled_q;
	step_t             step_q;
	logic [15:0]       rnd_q;
	logic [VAL_W-1:0]  shown_q;

	// divider
	logic [TIME_W-1:0] dt_q;
	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] quo_q;
	logic [4:0]        cnt_q;

	// tracking state
	logic [VAL_W-1:0]  last_moved_q;
	logic [TIME_W-1:0] last_time_q;
	logic [TIME_W-1:0] speed_q;
	logic              was_settled_q;
	logic [VAL_W-1:0]  drawn_value_q;
	logic [1:0]        drawn_unit_q;

	logic              m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [M_TUSER_W-1:0] m_tuser_q;

	// conversion
	logic [VAL_W-1:0]  pos_mag;
	logic [28:0]       inch_num;
	logic [58:0]       inch_prod;
	logic [VAL_W-1:0]  inch_mag;
	logic [VAL_W-1:0]  conv_v;

	// movement
	logic [VAL_W:0]    diff;
	logic [VAL_W-1:0]  delta_mag;
	logic [TIME_W-1:0] dt;
	logic              moved;
	logic [33:0]       dividend;
	logic              div_sat;

	// divide step
	logic [TIME_W:0]   trial;
	logic              take;
	logic [TIME_W-1:0] rem_next;

	// rounding
	logic [TIME_W-1:0] since_move;
	logic              settled;
	step_t             step_sel;
	logic [VAL_W-1:0]  v_mag;
	logic [VAL_W-1:0]  half;
	logic [27:0]       recip;
	logic [VAL_W-1:0]  rnd_x;
	logic [51:0]       rnd_prod;
	logic [9:0]        step_val;
	logic [25:0]       scaled;
	logic [VAL_W-1:0]  shown;

	// result flags
	logic [VAL_W:0]    ddiff;
	logic [VAL_W:0]    dmag;
	logic              just;
	logic              redraw;
	logic              meter;
	logic              out_free;
	logic              cfg_wr;
	logic [2:0]        reg_idx;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign pready   = 1'b1;
	assign out_free = !m_tvalid_q || m_tready;
	assign cfg_wr   = psel && penable && pwrite;
	assign reg_idx  = paddr[ADDR_W-1:2];

	always_comb begin
		unique case (reg_idx)
			REG_SETTLE_MS:  prdata = 32'(settle_ms_q);
			REG_FAST_SPEED: prdata = 32'(fast_speed_q);
			REG_SLOW_SPEED: prdata = 32'(slow_speed_q);
			REG_CHANGE_DB:  prdata = 32'(change_db_q);
			REG_REDRAW_DB:  prdata = 32'(redraw_db_q);
			default:        prdata = '0;
		endcase
	end

	// unit conversion
	always_comb begin
		pos_mag   = pos_q[VAL_W-1] ? (~pos_q + 24'd1) : pos_q;
		inch_num  = 29'(pos_mag) * INCH_MUL + INCH_BIAS;
		inch_prod = 59'(inch_num) * 59'(INCH_RECIP);
		inch_mag  = {1'b0, inch_prod[INCH_SHIFT +: VAL_W-1]};
		if (inch_q) begin
			conv_v = pos_q[VAL_W-1] ? (~inch_mag + 24'd1) : inch_mag;
		end else begin
			conv_v = pos_q;
		end
	end

	// movement test and divider setup
	always_comb begin
		diff      = {v_q[VAL_W-1], v_q} - {last_moved_q[VAL_W-1], last_moved_q};
		delta_mag = diff[VAL_W] ? 24'(~diff + 25'd1) : diff[VAL_W-1:0];
		dt        = time_q - last_time_q;
		moved     = (delta_mag > 24'(change_db_q)) && (dt != '0);
		dividend  = 34'(delta_mag) * SPEED_SCALE;
		// quotient needs more than 32 bits when the top bits alone reach dt
		div_sat   = 32'(dividend[33:32]) >= dt;
	end

	// one restoring divide step
	always_comb begin
		trial    = {rem_q, quo_q[TIME_W-1]};
		take     = trial >= {1'b0, dt_q};
		rem_next = take ? 32'(trial - {1'b0, dt_q}) : trial[TIME_W-1:0];
	end

	// step choice and rounding quotient
	always_comb begin
		since_move = time_q - last_time_q;
		settled    = since_move > 32'(settle_ms_q);
		if (speed_q > 32'(fast_speed_q)) begin
			step_sel = STEP_1000;
		end else if (speed_q > 32'(slow_speed_q)) begin
			step_sel = STEP_500;
		end else begin
			step_sel = STEP_200;
		end
		unique case (step_sel)
			STEP_1000: begin
				half  = 24'(STEP_1000_VAL >> 1);
				recip = RECIP_1000;
			end
			STEP_500: begin
				half  = 24'(STEP_500_VAL >> 1);
				recip = RECIP_500;
			end
			default: begin
				half  = 24'(STEP_200_VAL >> 1);
				recip = RECIP_200;
			end
		endcase
		v_mag    = v_q[VAL_W-1] ? (~v_q + 24'd1) : v_q;
		rnd_x    = v_mag + half;
		rnd_prod = 52'(rnd_x) * 52'(recip);
	end

	// scale back, restore sign, saturate
	always_comb begin
		unique case (step_q)
			STEP_1000: step_val = STEP_1000_VAL;
			STEP_500:  step_val = STEP_500_VAL;
			default:   step_val = STEP_200_VAL;
		endcase
		scaled = 26'(rnd_q) * 26'(step_val);
		if (settled_q) begin
			shown = v_q;
		end else if (v_q[VAL_W-1]) begin
			shown = (scaled > 26'(VAL_MIN)) ? VAL_MIN : 24'(~scaled + 26'd1);
		end else begin
			shown = (scaled > 26'(VAL_MAX)) ? VAL_MAX : scaled[VAL_W-1:0];
		end
	end

	// result flags
	always_comb begin
		ddiff  = {shown_q[VAL_W-1], shown_q} - {drawn_value_q[VAL_W-1], drawn_value_q};
		dmag   = ddiff[VAL_W] ? (~ddiff + 25'd1) : ddiff;
		just   = settled_q && !was_settled_q;
		redraw = (dmag > 25'(redraw_db_q)) || ({1'b0, inch_q} != drawn_unit_q) || just;
		meter  = !inch_q && ($signed(shown_q) >= $signed(METER_LIMIT));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			settle_ms_q   <= SETTLE_MS_RST;
			fast_speed_q  <= FAST_SPEED_RST;
			slow_speed_q  <= SLOW_SPEED_RST;
			change_db_q   <= CHANGE_DB_RST;
			redraw_db_q   <= REDRAW_DB_RST;
			pos_q         <= '0;
			time_q        <= '0;
			inch_q        <= 1'b0;
			v_q           <= '0;
			settled_q     <= 1'b0;
			step_q        <= STEP_200;
			rnd_q         <= '0;
			shown_q       <= '0;
			dt_q          <= '0;
			rem_q         <= '0;
			quo_q         <= '0;
			cnt_q         <= '0;
			last_moved_q  <= SENTINEL;
			last_time_q   <= '0;
			speed_q       <= '0;
			was_settled_q <= 1'b0;
			drawn_value_q <= SENTINEL;
			drawn_unit_q  <= UNIT_NONE;
			m_tvalid_q    <= 1'b0;
			m_tdata_q     <= '0;
			m_tuser_q     <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (reg_idx)
					REG_SETTLE_MS:  settle_ms_q  <= pwdata[15:0];
					REG_FAST_SPEED: fast_speed_q <= pwdata[19:0];
					REG_SLOW_SPEED: slow_speed_q <= pwdata[19:0];
					REG_CHANGE_DB:  change_db_q  <= pwdata[15:0];
					REG_REDRAW_DB:  redraw_db_q  <= pwdata[15:0];
					default: ;
				endcase
			end

			// a result leaving while the next one loads is refilled in ST_DONE
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						pos_q   <= s_tdata[VAL_W-1:0];
						time_q  <= s_tdata[VAL_W +: TIME_W];
						inch_q  <= s_tuser[0];
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					v_q     <= conv_v;
					state_q <= ST_DELTA;
				end
				ST_DELTA: begin
					if (moved) begin
						last_moved_q <= v_q;
						last_time_q  <= time_q;
						dt_q         <= dt;
						if (div_sat) begin
							speed_q <= '1;
							state_q <= ST_ROUND;
						end else begin
							rem_q   <= 32'(dividend[33:32]);
							quo_q   <= dividend[31:0];
							cnt_q   <= '0;
							state_q <= ST_DIV;
						end
					end else begin
						state_q <= ST_ROUND;
					end
				end
				ST_DIV: begin
					// shift in one quotient bit per cycle
					rem_q <= rem_next;
					quo_q <= {quo_q[TIME_W-2:0], take};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(DIV_STEPS - 1)) begin
						speed_q <= {quo_q[TIME_W-2:0], take};
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					settled_q <= settled;
					step_q    <= step_sel;
					rnd_q     <= rnd_prod[RND_SHIFT +: 16];
					state_q   <= ST_SCALE;
				end
				ST_SCALE: begin
					shown_q <= shown;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the output register can take the result
					if (out_free) begin
						was_settled_q <= settled_q;
						if (redraw) begin
							drawn_value_q <= shown_q;
							drawn_unit_q  <= {1'b0, inch_q};
						end
						m_tdata_q  <= shown_q;
						m_tuser_q  <= {meter, redraw, just};
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/vaq_checker.sv
// Port-level assertions for the velocity-adaptive readout quantizer, bound to the top level.
`default_nettype none

module vaq_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            s_tvalid,
	input wire                            s_tready,
	input wire                            m_tvalid,
	input wire                            m_tready,
	input wire [vaq_pkg::M_TDATA_W-1:0]   m_tdata,
	input wire [vaq_pkg::M_TUSER_W-1:0]   m_tuser
);
	import vaq_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one item at a time: busy right after a transfer in
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after accept");

	// settling always forces a redraw
	a_just_redraws: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tuser[0] || m_tuser[1])
		else $error("just_settled without redraw");

	// meter range only at or above the limit
	a_meter_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> $signed(m_tdata) >= $signed(METER_LIMIT))
		else $error("meter_range below limit");

endmodule

bind velocity_adaptive_readout_quantizer vaq_checker u_vaq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
